/* src/polygonal_number_test_assert.svh */
// Assertion macros for the polygonal number test.
// Included by the top level; needs nothing else.
`ifndef POLYGONAL_NUMBER_TEST_ASSERT_SVH
`define POLYGONAL_NUMBER_TEST_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define PNT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("polygonal_number_test: assertion failed");

// Checks that cons holds in the cycle after ante.
`define PNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("polygonal_number_test: assertion failed");

`endif

/* src/pnt_pkg.sv */
// Shared types and constants for the polygonal number test.
// Used by pnt_sub and polygonal_number_test; depends on nothing.
package pnt_pkg;

  localparam int unsigned SideW     = 16;
  localparam int unsigned CandW     = 32;
  localparam int unsigned RankW     = 32;
  localparam int unsigned InTdataW  = SideW + CandW;
  localparam int unsigned OutTdataW = RankW;

  typedef enum logic {
    OP_ROOT,
    OP_DIV
  } op_e;

endpackage

/* src/pnt_sub.sv */
// Shared trial-subtract unit of the polygonal number test: one step of the
// bit-pair square root or of the restoring division. Depends on pnt_pkg.
module pnt_sub #(
  parameter int unsigned SW  = 28,
  parameter int unsigned H   = 26,
  parameter int unsigned DVW = 17
) (
  input  pnt_pkg::op_e   op_i,
  input  logic [SW-1:0]  rem_i,
  input  logic [H-1:0]   root_i,
  input  logic [1:0]     pair_i,
  input  logic           nbit_i,
  input  logic [DVW-1:0] divisor_i,
  output logic [SW-1:0]  rem_o,
  output logic           ge_o
);

  logic [SW-1:0] a;
  logic [SW-1:0] b;
  logic [SW:0]   diff;

  always_comb begin
    case (op_i)
      pnt_pkg::OP_ROOT: begin
        a = SW'({rem_i[H-1:0], pair_i});
        b = SW'({root_i, 2'b01});
      end
      pnt_pkg::OP_DIV: begin
        a = SW'({rem_i[DVW-1:0], nbit_i});
        b = SW'(divisor_i);
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  assign diff  = {1'b0, a} - {1'b0, b};
  assign ge_o  = ~diff[SW];
  assign rem_o = ge_o ? diff[SW-1:0] : a;

endmodule

/* src/polygonal_number_test.sv */
// Top level of the polygonal number test: stream ports, sequencer and datapath.
// Depends on pnt_pkg, pnt_sub and polygonal_number_test_assert.svh.
//
// Each transfer on the input stream carries a side count s and a candidate n; one
// transfer on the output stream answers whether n is an s-gonal number and gives its
// rank k. For s >= 3 the block forms D = 8(s-2)n + (s-4)^2, takes its exact integer
// square root r, and divides r + s - 4 by 2(s-2); n is polygonal when both are exact.
// Side counts 0 and 1 accept only n = 1 (rank 1), side count 2 and n = 0 never match.
// The square root produces H = DW/2 root bits and the division works on an NW-bit
// dividend. A single subtractor is shared by the bit-pair square root (one root bit
// per cycle) and the restoring division (one quotient bit per cycle). When D is not
// a perfect square the division is skipped. Degenerate side counts and a zero
// candidate go straight from the idle state to the finish state. The input is not
// ready while a test is running; a finished result waits in the output register
// while the next input is taken.
`include "polygonal_number_test_assert.svh"

module polygonal_number_test #(
  parameter int unsigned NUM_BITS  = 32,
  parameter int unsigned SIDE_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: side_count[15:0], candidate[47:16].
  input  logic [pnt_pkg::InTdataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: rank[31:0].
  output logic [pnt_pkg::OutTdataW-1:0]   m_axis_tdata,
  // Fields from bit 0: is_polygonal.
  output logic                            m_axis_tuser
);

  localparam int unsigned PW   = SIDE_BITS + NUM_BITS + 3;
  localparam int unsigned A2W  = 2 * SIDE_BITS;
  localparam int unsigned DW0  = ((PW > A2W) ? PW : A2W) + 1;
  localparam int unsigned DW   = DW0 + (DW0 % 2);
  localparam int unsigned H    = DW / 2;
  localparam int unsigned HS   = (H > SIDE_BITS) ? H : SIDE_BITS;
  localparam int unsigned NW   = HS + 1;
  localparam int unsigned SW   = HS + 2;
  localparam int unsigned DVW  = SIDE_BITS + 1;
  localparam int unsigned CW   = $clog2(NW);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULN = 3'd1;
  localparam logic [2:0] ST_MULA = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_PREP = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_FIN  = 3'd7;

  logic [2:0]                   state_q, state_d;
  logic [CW-1:0]                cnt_q;
  logic                         out_valid_q;
  logic                         out_flag_q;
  logic [pnt_pkg::RankW-1:0]    out_rank_q;
  logic                         res_flag_q;
  logic [pnt_pkg::RankW-1:0]    res_rank_q;
  logic [SIDE_BITS-1:0]         s_q;
  logic [NUM_BITS-1:0]          n_q;
  logic [SIDE_BITS-1:0]         m_q;
  logic [PW-4:0]                prod_q;
  logic [A2W-1:0]               sq_q;
  logic [DW-1:0]                d_q;
  logic [SW-1:0]                rem_q;
  logic [H-1:0]                 root_q;
  logic [NW-1:0]                num_q;
  logic [NW-1:0]                quo_q;

  logic                         in_xfer;
  logic                         out_load;
  logic                         last_step;
  logic [SIDE_BITS-1:0]         side;
  logic [NUM_BITS-1:0]          cand;
  logic [SIDE_BITS-1:0]         dist4;
  pnt_pkg::op_e                 op;
  logic [SW-1:0]                rem_nxt;
  logic                         ge;

  assign side = SIDE_BITS'(s_axis_tdata[pnt_pkg::SideW-1:0]);
  assign cand = NUM_BITS'(s_axis_tdata[pnt_pkg::InTdataW-1:pnt_pkg::SideW]);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state_q == ST_FIN) & (~out_valid_q | m_axis_tready);
  assign last_step     = (cnt_q == '0);
  assign dist4         = (s_q >= SIDE_BITS'(4)) ? (s_q - SIDE_BITS'(4))
                                                : (SIDE_BITS'(4) - s_q);
  assign op            = (state_q == ST_DIV) ? pnt_pkg::OP_DIV : pnt_pkg::OP_ROOT;

  pnt_sub #(
    .SW  (SW),
    .H   (H),
    .DVW (DVW)
  ) u_sub (
    .op_i      (op),
    .rem_i     (rem_q),
    .root_i    (root_q),
    .pair_i    (d_q[DW-1:DW-2]),
    .nbit_i    (num_q[NW-1]),
    .divisor_i ({m_q, 1'b0}),
    .rem_o     (rem_nxt),
    .ge_o      (ge)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (side <= SIDE_BITS'(2) || cand == '0) begin
            state_d = ST_FIN;
          end else begin
            state_d = ST_MULN;
          end
        end
      end
      ST_MULN: state_d = ST_MULA;
      ST_MULA: state_d = ST_SUM;
      ST_SUM:  state_d = ST_SQRT;
      ST_SQRT: begin
        if (last_step) begin
          state_d = (rem_nxt == '0) ? ST_PREP : ST_FIN;
        end
      end
      ST_PREP: state_d = ST_DIV;
      ST_DIV: begin
        if (last_step) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SUM) begin
        cnt_q <= CW'(H - 1);
      end else if (state_q == ST_PREP) begin
        cnt_q <= CW'(NW - 1);
      end else if (!last_step) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        s_q        <= side;
        n_q        <= cand;
        m_q        <= side - SIDE_BITS'(2);
        res_flag_q <= (side <= SIDE_BITS'(1)) && (cand == NUM_BITS'(1));
        res_rank_q <= ((side <= SIDE_BITS'(1)) && (cand == NUM_BITS'(1)))
                      ? pnt_pkg::RankW'(1) : '0;
      end
      ST_MULN: prod_q <= m_q * n_q;
      ST_MULA: sq_q <= dist4 * dist4;
      ST_SUM: begin
        d_q    <= DW'({prod_q, 3'b000}) + DW'(sq_q);
        rem_q  <= '0;
        root_q <= '0;
      end
      ST_SQRT: begin
        rem_q      <= rem_nxt;
        root_q     <= {root_q[H-2:0], ge};
        d_q        <= {d_q[DW-3:0], 2'b00};
        res_flag_q <= 1'b0;
        res_rank_q <= '0;
      end
      ST_PREP: begin
        num_q <= NW'(root_q) + NW'(s_q) - NW'(4);
        rem_q <= '0;
        quo_q <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_nxt;
        quo_q <= {quo_q[NW-2:0], ge};
        num_q <= {num_q[NW-2:0], 1'b0};
        if (last_step) begin
          res_flag_q <= (rem_nxt == '0);
          res_rank_q <= (rem_nxt == '0) ? pnt_pkg::RankW'({quo_q[NW-2:0], ge}) : '0;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          out_flag_q <= res_flag_q;
          out_rank_q <= res_rank_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_rank_q;
  assign m_axis_tuser  = out_flag_q;

  `PNT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_xfer, !s_axis_tready)
  `PNT_ASSERT_SAME(a_match_rank, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
                   m_axis_tdata != '0)
  `PNT_ASSERT_SAME(a_miss_rank, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
                   m_axis_tdata == '0)
  `PNT_ASSERT_SAME(a_root_count, clk_i, rst_ni, state_q == ST_SQRT,
                   cnt_q <= CW'(H - 1))

endmodule

/* tb/sv/polygonal_number_test_test.sv */
// Self-checking testbench for polygonal_number_test: drives side count and candidate
// transfers, predicts flag and rank in a scoreboard class, and checks every result.
// Depends on pnt_pkg and the polygonal_number_test RTL only.
module polygonal_number_test_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RankSearchBits = (pnt_pkg::CandW + 3) / 2;
  localparam int unsigned IdleLimit      = 4000;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned RandomItems    = 1080;

  typedef struct packed {
    logic [15:0] side;
    logic [31:0] cand;
    logic        is_poly;
    logic [31:0] rank;
  } answer_t;

  class rank_scoreboard;
    answer_t     pending_answers[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
    endfunction

    function answer_t polygonal_answer(logic [15:0] side, logic [31:0] cand);
      answer_t    ans;
      bit [63:0]  s, n, m, lo, hi, mid, tri_k;
      ans = '0;
      ans.side = side;
      ans.cand = cand;
      s = 64'(side);
      n = 64'(cand);
      if (s <= 1) begin
        if (n == 1) begin
          ans.is_poly = 1'b1;
          ans.rank    = 32'd1;
        end
        return ans;
      end
      if (s == 2 || n == 0) return ans;
      m  = s - 2;
      lo = 1;
      hi = 64'd1 << RankSearchBits;
      while (hi - lo > 1) begin
        mid   = lo + ((hi - lo) >> 1);
        tri_k = (mid * (mid - 1)) >> 1;
        if (mid <= n && tri_k <= (n - mid) / m) lo = mid;
        else hi = mid;
      end
      tri_k = (lo * (lo - 1)) >> 1;
      if (lo <= n && ((n - lo) % m) == 0 && (n - lo) / m == tri_k) begin
        ans.is_poly = 1'b1;
        ans.rank    = lo[31:0];
      end
      return ans;
    endfunction

    function void note_request(logic [15:0] side, logic [31:0] cand);
      pending_answers.push_back(polygonal_answer(side, cand));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      fail_count++;
    endtask

    task check_result(logic flag, logic [31:0] rank);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result flag=%0b rank=%0d with no request pending",
                                  flag, rank));
        return;
      end
      want = pending_answers.pop_front();
      if (flag !== want.is_poly)
        report_mismatch($sformatf("s=%0d n=%0d flag got %0b want %0b",
                                  want.side, want.cand, flag, want.is_poly));
      if (rank !== want.rank)
        report_mismatch($sformatf("s=%0d n=%0d rank got %0d want %0d",
                                  want.side, want.cand, rank, want.rank));
    endtask
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [pnt_pkg::InTdataW-1:0]   s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [pnt_pkg::OutTdataW-1:0]  m_axis_tdata;
  logic                           m_axis_tuser;

  rank_scoreboard sb;
  bit             steady_flow;
  bit             long_hold_request;
  int unsigned    idle_cycles;

  polygonal_number_test u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit [63:0] polygonal_value(logic [15:0] side, bit [63:0] k);
    bit [63:0] m;
    m = 64'(side);
    m = m - 2;
    return k + m * ((k * (k - 1)) >> 1);
  endfunction

  task automatic send_request(logic [15:0] side, logic [31:0] cand);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {cand, side};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(side, cand);
  endtask

  task automatic send_shape(logic [15:0] side, bit [63:0] k, int delta);
    bit [63:0] n;
    n = polygonal_value(side, k) + delta;
    send_request(side, n[31:0]);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    logic [15:0] side;
    bit [63:0]   k;
    int          delta;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_request(16'($urandom), $urandom);
    end else if (pick < 16) begin
      side = 16'($urandom_range(0, 2));
      send_request(side, ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2) : $urandom);
    end else begin
      pick = $urandom_range(0, 9);
      if (pick < 5) side = 16'($urandom_range(3, 12));
      else if (pick < 8) side = 16'($urandom_range(3, 1000));
      else side = 16'($urandom_range(3, 65535));
      if ($urandom_range(0, 1) != 0) k = 64'($urandom_range(1, 30));
      else k = 64'($urandom_range(1, (1 << RankSearchBits) - 1));
      while (polygonal_value(side, k) > 64'hFFFF_FFFF) k = k >> 1;
      delta = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2)) - 1 : 0;
      send_shape(side, k, delta);
    end
  endtask

  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 9);
      if (long_hold_request) begin
        stall = LongHoldCycles;
        long_hold_request = 1'b0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAIL polygonal_number_test");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    sb                = new();
    steady_flow       = 1'b0;
    long_hold_request = 1'b0;
    idle_cycles       = 0;
    rst_ni            = 1'b0;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(16'd0, 32'd1);
    send_request(16'd0, 32'd0);
    send_request(16'd1, 32'd1);
    send_request(16'd1, 32'hFFFF_FFFF);
    send_request(16'd2, 32'd1);
    send_request(16'd2, 32'd0);
    send_request(16'd3, 32'd0);
    send_request(16'd3, 32'd1);
    send_request(16'd3, 32'hFFFF_FFFF);
    send_shape(16'd3, 64'd92681, 0);
    send_shape(16'd3, 64'd92681, 1);
    send_shape(16'd4, 64'd65535, 0);
    send_shape(16'd4, 64'd65535, -1);
    send_request(16'd4, 32'd2);
    send_shape(16'd5, 64'd7, 0);
    send_shape(16'd6, 64'd1000, 0);
    send_request(16'hFFFF, 32'd0);
    send_request(16'hFFFF, 32'd1);
    send_request(16'hFFFF, 32'hFFFF);
    send_request(16'hFFFF, 32'hFFFF_FFFF);
    send_shape(16'hFFFF, 64'd3, 0);
    send_shape(16'hFFFF, 64'd3, 1);
    send_request(16'h8000, 32'h8000_0000);

    for (int unsigned i = 0; i < RandomItems; i++) begin
      steady_flow = (i >= 200 && i < 400) || (i >= 800 && i < 900);
      if (i == 600) long_hold_request = 1'b1;
      send_random_request();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending_answers.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.pending_answers.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending_answers.size()));
    if (sb.fail_count == 0) begin
      $display("PASS polygonal_number_test");
    end else begin
      $display("FAIL polygonal_number_test");
    end
    $finish;
  end

endmodule
